### hdl/rlqm_pkg.sv
// Package for the resource lock queue manager: payload structs, request and
// reply codes, controller states and the controller/datapath command and status.
// No dependencies.
`default_nettype none

package rlqm_pkg;

  localparam int unsigned NUM_RESOURCES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF   = 8;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned RES_ID_W = 4;
  localparam int unsigned CLIENT_W = 32;
  localparam int unsigned REPLY_W  = 2;

  // Request kinds; every other code is echoed back.
  localparam logic [MODE_W-1:0] MODE_ENTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAVE = 2'd1;

  localparam logic [REPLY_W-1:0] REPLY_GRANTED  = 2'd0;
  localparam logic [REPLY_W-1:0] REPLY_WAIT     = 2'd1;
  localparam logic [REPLY_W-1:0] REPLY_RELEASED = 2'd2;
  localparam logic [REPLY_W-1:0] REPLY_ECHO     = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [RES_ID_W-1:0] resource_id;
    logic [CLIENT_W-1:0] client_id;
  } in_item_t;

  typedef struct packed {
    logic [REPLY_W-1:0]  reply;
    logic [RES_ID_W-1:0] reply_resource;
    logic                overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_LEAVE_CHK,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic               latch;     // capture request and queue pointers
    logic               step;      // advance the scan to the next entry
    logic               append;    // write client at the tail, count up
    logic               pop;       // advance head, count down
    logic               set_res;   // record the reply
    logic [REPLY_W-1:0] reply;
    logic               overflow;
    logic               load_out;  // move the reply into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic is_enter;
    logic is_leave;
    logic in_range;
    logic cnt_zero;
    logic cnt_full;
    logic match;       // store read data equals the requesting client
    logic last;        // entry under compare is the newest one queued
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/resource_lock_queue_manager.sv
// Channel  Ports                        Payload
// in       in_valid / in_ready          rlqm_pkg::in_item_t  (mode, resource_id, client_id)
// out      out_valid / out_ready        rlqm_pkg::out_item_t (reply, reply_resource, overflow)
//
// One request at a time: an accept state, a decision state and a state that
// loads the output register, plus a scan for an enter on a queue that already
// holds clients, which compares the queued clients in turn (one store read per
// cycle; a match ends the scan early), or one check for a leave on a busy queue.
// The next request is taken only once the last one has been moved into the
// output register.
// Reset clears every head and count register at once; store entries are only
// read after they were written. A stalled result holds the block in its final
// state until the output register is free.
// Top level of the resource lock queue manager; depends on rlqm_pkg,
// rlqm_ctrl and rlqm_datapath.
`default_nettype none

module resource_lock_queue_manager #(
  parameter int unsigned NUM_RESOURCES = rlqm_pkg::NUM_RESOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH   = rlqm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rlqm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rlqm_pkg::out_item_t      out_data
);
  import rlqm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rlqm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlqm_datapath #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### hdl/rlqm_ctrl.sv
// Controller state machine of the resource lock queue manager.
// Depends on rlqm_pkg; drives datapath commands and the output valid flag.
`default_nettype none

module rlqm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rlqm_pkg::dp_stat_t stat,
  output rlqm_pkg::dp_cmd_t      cmd
);
  import rlqm_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.reply = REPLY_WAIT;
        if (!(stat.is_enter || stat.is_leave)) begin
          cmd.set_res = 1'b1;
          cmd.reply   = REPLY_ECHO;
          state_nxt   = ST_DONE;
        end else if (!stat.in_range) begin
          cmd.set_res = 1'b1;
          state_nxt   = ST_DONE;
        end else if (stat.is_enter) begin
          if (stat.cnt_zero) begin
            cmd.append  = 1'b1;
            cmd.set_res = 1'b1;
            cmd.reply   = REPLY_GRANTED;
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end else if (stat.cnt_zero) begin
          cmd.set_res = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          state_nxt = ST_LEAVE_CHK;
        end
      end
      ST_SCAN: begin
        cmd.reply = REPLY_WAIT;
        if (stat.match) begin
          cmd.set_res = 1'b1;
          state_nxt   = ST_DONE;
        end else if (stat.last) begin
          // Client is not queued yet: append it unless the ring is full.
          cmd.set_res  = 1'b1;
          cmd.overflow = stat.cnt_full;
          cmd.append   = !stat.cnt_full;
          state_nxt    = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_LEAVE_CHK: begin
        cmd.set_res = 1'b1;
        if (stat.match) begin
          cmd.pop   = 1'b1;
          cmd.reply = REPLY_RELEASED;
        end else begin
          cmd.reply = REPLY_WAIT;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

`default_nettype wire

### hdl/rlqm_datapath.sv
// Datapath of the resource lock queue manager: waiter store memory, per-resource
// head and count registers, request latch, scan counter and output register.
// Depends on rlqm_pkg; commanded by rlqm_ctrl.
`default_nettype none

module rlqm_datapath #(
  parameter int unsigned NUM_RESOURCES = rlqm_pkg::NUM_RESOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH   = rlqm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rlqm_pkg::in_item_t in_data,
  input  wire rlqm_pkg::dp_cmd_t  cmd,
  output rlqm_pkg::dp_stat_t      stat,
  output rlqm_pkg::out_item_t     out_data
);
  import rlqm_pkg::*;

  localparam int unsigned RES_AW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int unsigned HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW     = CW + 1;
  localparam int unsigned DEPTH  = NUM_RESOURCES * QUEUE_DEPTH;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [AW-1:0] QD_A = AW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] QD_S = SW'(QUEUE_DEPTH);
  localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);

  // Ring slot of the k-th entry; head + k stays below twice the depth.
  function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] head,
                                            input logic [CW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(k);
    if (sum >= QD_S) begin
      sum = sum - QD_S;
    end
    return sum[HW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RES_AW-1:0] idx,
                                            input logic [HW-1:0] slot);
    return AW'(idx) * QD_A + AW'(slot);
  endfunction

  logic [CLIENT_W-1:0] mem [DEPTH];
  logic [CLIENT_W-1:0] rd_data_r;
  logic [HW-1:0]       head_arr_r [NUM_RESOURCES];
  logic [CW-1:0]       cnt_arr_r  [NUM_RESOURCES];

  in_item_t            req_r;
  logic [RES_AW-1:0]   idx_r;
  logic                in_range_r;
  logic [HW-1:0]       head_q_r;
  logic [CW-1:0]       cnt_q_r;
  logic [CW-1:0]       k_r, k_nxt;
  logic [REPLY_W-1:0]  reply_r;
  logic                ovf_r;
  out_item_t           out_r;

  logic [RES_AW-1:0]   in_idx;
  logic                in_range;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [HW-1:0]       head_inc;

  assign in_idx   = RES_AW'(in_data.resource_id);
  assign in_range = 32'(in_data.resource_id) < NUM_RESOURCES;

  // The store is read at the entry that is compared in the next cycle.
  assign k_nxt    = cmd.latch ? '0 : (cmd.step ? k_r + CW'(1) : k_r);
  assign rd_addr  = addr_of(idx_r, slot_of(head_q_r, k_nxt));
  assign wr_addr  = addr_of(idx_r, slot_of(head_q_r, cnt_q_r));
  assign head_inc = (head_q_r == HEAD_LAST) ? '0 : head_q_r + HW'(1);

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[wr_addr] <= req_r.client_id;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(NUM_RESOURCES); i++) begin
        head_arr_r[i] <= '0;
        cnt_arr_r[i]  <= '0;
      end
    end else if (cmd.append) begin
      cnt_arr_r[idx_r] <= cnt_q_r + CW'(1);
    end else if (cmd.pop) begin
      head_arr_r[idx_r] <= head_inc;
      cnt_arr_r[idx_r]  <= cnt_q_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r      <= in_data;
      idx_r      <= in_idx;
      in_range_r <= in_range;
      head_q_r   <= in_range ? head_arr_r[in_idx] : '0;
      cnt_q_r    <= in_range ? cnt_arr_r[in_idx] : '0;
    end
    k_r <= k_nxt;
    if (cmd.set_res) begin
      reply_r <= cmd.reply;
      ovf_r   <= cmd.overflow;
    end
    if (cmd.load_out) begin
      out_r.reply          <= reply_r;
      out_r.reply_resource <= req_r.resource_id;
      out_r.overflow       <= ovf_r;
    end
  end

  assign out_data = out_r;

  assign stat.is_enter = (req_r.mode == MODE_ENTER);
  assign stat.is_leave = (req_r.mode == MODE_LEAVE);
  assign stat.in_range = in_range_r;
  assign stat.cnt_zero = (cnt_q_r == '0);
  assign stat.cnt_full = (cnt_q_r == QD_C);
  assign stat.match    = (rd_data_r == req_r.client_id);
  assign stat.last     = ((k_r + CW'(1)) == cnt_q_r);

endmodule

`default_nettype wire

### hdl/rlqm_checker.sv
// Port-level checks for the resource lock queue manager, bound to the top level.
// Depends on rlqm_pkg and resource_lock_queue_manager.
`default_nettype none

module rlqm_checker #(
  parameter int unsigned NUM_RESOURCES = rlqm_pkg::NUM_RESOURCES_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire rlqm_pkg::out_item_t out_data
);
  import rlqm_pkg::*;

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is in work");

  // A dropped append is always reported as wait.
  a_ovf_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.reply == REPLY_WAIT)
    else $error("overflow with a reply other than wait");

  // Queue changes and overflow only happen for an existing resource.
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.reply == REPLY_GRANTED || out_data.reply == REPLY_RELEASED ||
                  out_data.overflow)
    |-> 32'(out_data.reply_resource) < NUM_RESOURCES)
    else $error("queue activity reported for a resource out of range");

endmodule

bind resource_lock_queue_manager rlqm_checker #(
  .NUM_RESOURCES (NUM_RESOURCES)
) u_rlqm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
